/* rtl/led_command_sequencer_defines.svh */
// assertion macros shared by the led command sequencer modules
`ifndef LED_COMMAND_SEQUENCER_DEFINES_SVH
`define LED_COMMAND_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LCS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lcs_pkg.sv */
// package with constants, codes and types of the led command sequencer
`timescale 1ns / 1ps

package lcs_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CMD_OFF  = 8'h30;
  localparam logic [7:0] CMD_LIT  = 8'h31;
  localparam logic [7:0] CMD_DARK = 8'h32;
  localparam logic [7:0] CMD_ON   = 8'h33;

  typedef enum logic [2:0] {
    MSG_NONE  = 3'd0,
    MSG_OFF   = 3'd1,
    MSG_LIT   = 3'd2,
    MSG_DARK  = 3'd3,
    MSG_ON    = 3'd4,
    MSG_BAD   = 3'd5,
    MSG_EMPTY = 3'd6
  } msg_t;

  // item waiting between the fifo access and command execution
  typedef struct packed {
    logic valid;
    logic func;
    logic empty;
    logic dropped;
  } lcs_stage_t;

endpackage

/* rtl/lcs_if.sv */
// channel interfaces of the led command sequencer
`timescale 1ns / 1ps

interface lcs_item_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface lcs_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] led_bits;
  logic [2:0] message_code;
  logic       byte_dropped;

  modport source (output valid, output led_bits, output message_code,
                  output byte_dropped, input ready);
  modport sink (input valid, input led_bits, input message_code,
                input byte_dropped, output ready);
endinterface

/* rtl/led_command_sequencer.sv */
// top level of the led command sequencer
`timescale 1ns / 1ps

// led command sequencer
// item channel: func = 0 carries a received command byte in rx_byte, which
//   is queued in an eight-entry command fifo, or dropped (byte_dropped = 1)
//   when the fifo is full; func = 1 is a step tick that pops one command
// a tick executes the popped command: '0' off, '3' on, '1' lit led sweep,
//   '2' dark led sweep; other bytes report incorrect and change nothing;
//   on an empty fifo the last valid command runs again and reports empty
// result channel: exactly one transaction per item, in item order
// result path: the accepting edge loads the item into the stage register
//   (a pop also reads the fifo memory); the stage executes into the output
//   register when that register is empty or its result is being taken
// throughput: one item per cycle while results are taken; fifo memory
//   and sweep state see one access per item, so items flow back to back
// a stalled receiver holds the result register; one more item is taken
//   into the stage after the memory, then item ready drops until the
//   result is taken
// reset: synchronous, active high; fifo empty, last command '0', leds off;
//   fifo memory contents are not cleared and need no clearing pass
module led_command_sequencer (
  input  logic          clk,
  input  logic          rst,
  lcs_item_if.sink      item,
  lcs_result_if.source  result
);
  import lcs_pkg::*;

  lcs_stage_t stage;
  logic [7:0] cmd_byte;
  logic       advance;

  // fifo access and the stage that waits on the memory read
  lcs_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .advance  (advance),
    .stage    (stage),
    .cmd_byte (cmd_byte)
  );

  // command execution and output register
  lcs_executor u_exec (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .cmd_byte (cmd_byte),
    .advance  (advance),
    .result   (result)
  );

endmodule

/* rtl/lcs_cmd_fifo.sv */
// command fifo: memory, pointers, fill count and the stage after the read
`timescale 1ns / 1ps
`include "led_command_sequencer_defines.svh"

module lcs_cmd_fifo (
  input  logic               clk,
  input  logic               rst,
  lcs_item_if.sink           item,
  input  logic               advance,
  output lcs_pkg::lcs_stage_t stage,
  output logic [7:0]         cmd_byte
);
  import lcs_pkg::*;

  logic [7:0]       store [FIFO_DEPTH];
  logic [7:0]       rd_data;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill_count;
  lcs_stage_t       stage_reg;
  logic             accept;
  logic             full;
  logic             empty;
  logic             do_push;
  logic             do_pop;

  assign item.ready = !stage_reg.valid || advance;
  assign accept     = item.valid && item.ready;
  assign full       = (fill_count == CNT_W'(FIFO_DEPTH));
  assign empty      = (fill_count == '0);
  assign do_push    = accept && !item.func && !full;
  assign do_pop     = accept && item.func && !empty;

  assign stage    = stage_reg;
  assign cmd_byte = rd_data;

  // memory with registered read
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= item.rx_byte;
    end
    if (do_pop) begin
      rd_data <= store[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fill_count <= '0;
      stage_reg  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr     <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        fill_count <= fill_count + 1'b1;
      end
      if (do_pop) begin
        rd_ptr     <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        fill_count <= fill_count - 1'b1;
      end
      if (accept) begin
        stage_reg.valid   <= 1'b1;
        stage_reg.func    <= item.func;
        stage_reg.empty   <= item.func && empty;
        stage_reg.dropped <= !item.func && full;
      end else if (advance) begin
        stage_reg.valid <= 1'b0;
      end
    end
  end

  `LCS_ASSERT_NOW(fill_in_range, clk, rst, 1'b1, fill_count <= CNT_W'(FIFO_DEPTH), "fill count above depth")
  `LCS_ASSERT_NEXT(drop_when_full, clk, rst, accept && !item.func && full, stage_reg.valid && stage_reg.dropped, "full fifo did not drop byte")
  `LCS_ASSERT_NEXT(stage_holds, clk, rst, stage_reg.valid && !advance, stage_reg.valid, "stalled stage lost its item")

endmodule

/* rtl/lcs_executor.sv */
// command execution, sweep state and output register
`timescale 1ns / 1ps
`include "led_command_sequencer_defines.svh"

module lcs_executor (
  input  logic                clk,
  input  logic                rst,
  input  lcs_pkg::lcs_stage_t stage,
  input  logic [7:0]          cmd_byte,
  output logic                advance,
  lcs_result_if.source        result
);
  import lcs_pkg::*;

  logic [7:0] last_command;
  logic [2:0] cur_pos;
  logic [2:0] prev_pos;
  logic [2:0] led_reg;

  logic [7:0] last_command_next;
  logic [2:0] cur_pos_next;
  logic [2:0] prev_pos_next;
  logic [2:0] led_reg_next;
  msg_t       msg_next;

  logic [7:0] cmd;
  logic       fresh;
  logic [2:0] cp;
  logic [2:0] pp;
  logic       moved;
  logic [2:0] one_hot;
  logic       fire;

  assign advance = !result.valid || result.ready;
  assign fire    = stage.valid && advance;
  assign cmd     = stage.empty ? last_command : cmd_byte;
  assign fresh   = (cmd != last_command);

  always_comb begin
    last_command_next = last_command;
    cur_pos_next      = cur_pos;
    prev_pos_next     = prev_pos;
    led_reg_next      = led_reg;
    msg_next          = MSG_NONE;
    cp                = fresh ? 3'd4 : cur_pos;
    pp                = fresh ? 3'd5 : prev_pos;
    moved             = 1'b0;
    one_hot           = 3'b100;
    if (stage.func) begin
      case (cmd)
        CMD_OFF: begin
          msg_next          = MSG_OFF;
          led_reg_next      = 3'b000;
          last_command_next = cmd;
        end
        CMD_ON: begin
          msg_next          = MSG_ON;
          led_reg_next      = 3'b111;
          last_command_next = cmd;
        end
        CMD_LIT, CMD_DARK: begin
          msg_next          = (cmd == CMD_LIT) ? MSG_LIT : MSG_DARK;
          last_command_next = cmd;
          cur_pos_next      = cp;
          prev_pos_next     = pp;
          if (cp inside {3'd3, 3'd5}) begin
            prev_pos_next = cp;
            cur_pos_next  = 3'd4;
            moved         = 1'b1;
          end else if (cp == 3'd4 && pp == 3'd3) begin
            cur_pos_next = 3'd5;
            moved        = 1'b1;
          end else if (cp == 3'd4 && pp == 3'd5) begin
            cur_pos_next = 3'd3;
            moved        = 1'b1;
          end
          case (cur_pos_next)
            3'd3:    one_hot = 3'b001;
            3'd4:    one_hot = 3'b010;
            default: one_hot = 3'b100;
          endcase
          if (moved) begin
            led_reg_next = (cmd == CMD_LIT) ? one_hot : (3'b111 ^ one_hot);
          end
        end
        default: begin
          msg_next = MSG_BAD;
        end
      endcase
      if (stage.empty) begin
        msg_next = MSG_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_command <= CMD_OFF;
      cur_pos      <= '0;
      prev_pos     <= '0;
      led_reg      <= '0;
      result.valid <= 1'b0;
    end else begin
      if (fire) begin
        last_command <= last_command_next;
        cur_pos      <= cur_pos_next;
        prev_pos     <= prev_pos_next;
        led_reg      <= led_reg_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with its transaction
  always_ff @(posedge clk) begin
    if (fire) begin
      result.led_bits     <= led_reg_next;
      result.message_code <= msg_next;
      result.byte_dropped <= stage.dropped;
    end
  end

  `LCS_ASSERT_NOW(on_lights_all, clk, rst, result.valid && result.message_code == MSG_ON, result.led_bits == 3'b111, "on message without all leds lit")
  `LCS_ASSERT_NOW(off_darks_all, clk, rst, result.valid && result.message_code == MSG_OFF, result.led_bits == 3'b000, "off message with a led lit")
  `LCS_ASSERT_NOW(drop_no_message, clk, rst, result.valid && result.byte_dropped, result.message_code == MSG_NONE, "dropped byte carries a message")

endmodule
